@@ sv/pncm_pkg.sv @@
`default_nettype none

package pncm_pkg;

  localparam int unsigned PalEntries = 256;
  localparam int unsigned IdxW       = $clog2(PalEntries);
  localparam int unsigned ChanW      = 8;
  localparam int unsigned FieldIdxW  = 8;
  localparam int unsigned SqW        = 2 * ChanW;
  localparam int unsigned DistW      = 18;
  localparam int unsigned BestW      = 24;
  localparam int unsigned ColourW    = 3 * ChanW;

  localparam logic [BestW-1:0] NoMatchYet = BestW'(255 * 255 * 255);
  localparam logic [IdxW-1:0]  LastIdx    = IdxW'(PalEntries - 1);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_MATCH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } back_state_e;

  typedef struct packed {
    logic             is_match;
    logic             blocked;
    logic [IdxW-1:0]  waddr;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } item_t;

endpackage

`default_nettype wire

@@ sv/pncm_front.sv @@
`default_nettype none

module pncm_front (
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [pncm_pkg::FieldIdxW-1:0] entry_index_i,
  input  wire logic [pncm_pkg::ChanW-1:0]    red_i,
  input  wire logic [pncm_pkg::ChanW-1:0]    green_i,
  input  wire logic [pncm_pkg::ChanW-1:0]    blue_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output pncm_pkg::item_t                    item_o
);

  logic is_zero, is_last, beyond;

  // Protected: first entry, last entry, and anything past the palette.
  assign is_zero = (entry_index_i == '0);
  assign is_last = ({1'b0, entry_index_i} == 9'(pncm_pkg::PalEntries - 1));
  assign beyond  = ({1'b0, entry_index_i} >= 9'(pncm_pkg::PalEntries));

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.is_match = (pncm_pkg::action_e'(action_i) == pncm_pkg::ACT_MATCH);
    item_o.blocked  = is_zero || is_last || beyond;
    item_o.waddr    = entry_index_i[pncm_pkg::IdxW-1:0];
    item_o.red      = red_i;
    item_o.green    = green_i;
    item_o.blue     = blue_i;
  end

endmodule

`default_nettype wire

@@ sv/pncm_queue.sv @@
`default_nettype none

module pncm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire pncm_pkg::item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output pncm_pkg::item_t      item_o,
  input  wire logic            pop_i
);

  pncm_pkg::item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/pncm_back.sv @@
`default_nettype none

module pncm_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire pncm_pkg::item_t                 q_item_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [pncm_pkg::FieldIdxW-1:0]       match_index_o,
  output logic [pncm_pkg::DistW-1:0]           match_distance_o,
  output logic                                 write_ignored_o
);

  pncm_pkg::back_state_e state_q, state_d;

  logic [pncm_pkg::ColourW-1:0] pal_mem [pncm_pkg::PalEntries];
  logic [pncm_pkg::PalEntries-1:0] vld_q;

  logic [pncm_pkg::IdxW-1:0]  cnt_q;
  logic [pncm_pkg::ChanW-1:0] qr_q, qg_q, qb_q;

  // read stage
  logic [pncm_pkg::ColourW-1:0] rd_data_q;
  logic                         rd_vld_q;
  logic                         s1_vld_q, s1_last_q;
  logic [pncm_pkg::IdxW-1:0]    s1_idx_q;

  // square stage
  logic [pncm_pkg::SqW-1:0]  sq_r_q, sq_g_q, sq_b_q;
  logic                      s2_vld_q, s2_last_q;
  logic [pncm_pkg::IdxW-1:0] s2_idx_q;

  // compare stage
  logic [pncm_pkg::BestW-1:0] best_q;
  logic [pncm_pkg::IdxW-1:0]  best_idx_q;

  logic out_vld_q;
  logic [pncm_pkg::FieldIdxW-1:0] out_idx_q;
  logic [pncm_pkg::DistW-1:0]     out_dist_q;
  logic                           out_ign_q;

  logic out_free, start_match, do_write, rd_en, fin;
  logic [pncm_pkg::ChanW-1:0] cr, cg, cb, dr, dg, db;
  logic [pncm_pkg::DistW-1:0] dsum;
  logic                       take;

  function automatic logic [pncm_pkg::ChanW-1:0] abs_diff(
      input logic [pncm_pkg::ChanW-1:0] a,
      input logic [pncm_pkg::ChanW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign out_free = !out_vld_q || !out_stall_i;
  assign fin      = s2_vld_q && s2_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pncm_pkg::ST_IDLE: begin
        if (q_valid_i && out_free && q_item_i.is_match) state_d = pncm_pkg::ST_SCAN;
      end
      pncm_pkg::ST_SCAN: begin
        if (cnt_q == pncm_pkg::LastIdx) state_d = pncm_pkg::ST_DRAIN;
      end
      pncm_pkg::ST_DRAIN: begin
        if (fin) state_d = pncm_pkg::ST_IDLE;
      end
      default: state_d = pncm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    rd_en = 1'b0;
    case (state_q)
      pncm_pkg::ST_IDLE: pop_o = q_valid_i && out_free;
      pncm_pkg::ST_SCAN: rd_en = 1'b1;
      default: begin
        pop_o = 1'b0;
        rd_en = 1'b0;
      end
    endcase
  end

  assign start_match = pop_o && q_item_i.is_match;
  assign do_write    = pop_o && !q_item_i.is_match && !q_item_i.blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pncm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // palette memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      pal_mem[q_item_i.waddr] <= {q_item_i.red, q_item_i.green, q_item_i.blue};
    end
    if (rd_en) begin
      rd_data_q <= pal_mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (do_write) vld_q[q_item_i.waddr] <= 1'b1;
      if (rd_en) rd_vld_q <= vld_q[cnt_q];
    end
  end

  // scan counter and query colour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_match) begin
      cnt_q <= '0;
    end else if (rd_en) begin
      cnt_q <= cnt_q + pncm_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_match) begin
      qr_q <= q_item_i.red;
      qg_q <= q_item_i.green;
      qb_q <= q_item_i.blue;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= rd_en;
      s2_vld_q <= s1_vld_q;
    end
  end

  // never-written entries read as zero
  assign cr = rd_vld_q ? rd_data_q[3*pncm_pkg::ChanW-1:2*pncm_pkg::ChanW] : '0;
  assign cg = rd_vld_q ? rd_data_q[2*pncm_pkg::ChanW-1:pncm_pkg::ChanW]   : '0;
  assign cb = rd_vld_q ? rd_data_q[pncm_pkg::ChanW-1:0]                   : '0;
  assign dr = abs_diff(cr, qr_q);
  assign dg = abs_diff(cg, qg_q);
  assign db = abs_diff(cb, qb_q);

  assign dsum = pncm_pkg::DistW'(sq_r_q) + pncm_pkg::DistW'(sq_g_q)
              + pncm_pkg::DistW'(sq_b_q);
  assign take = (pncm_pkg::BestW'(dsum) < best_q);

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= cnt_q;
    s1_last_q <= (cnt_q == pncm_pkg::LastIdx);
    sq_r_q    <= pncm_pkg::SqW'(dr) * pncm_pkg::SqW'(dr);
    sq_g_q    <= pncm_pkg::SqW'(dg) * pncm_pkg::SqW'(dg);
    sq_b_q    <= pncm_pkg::SqW'(db) * pncm_pkg::SqW'(db);
    s2_idx_q  <= s1_idx_q;
    s2_last_q <= s1_last_q;
    if (start_match) begin
      best_q     <= pncm_pkg::NoMatchYet;
      best_idx_q <= '0;
    end else if (s2_vld_q && take) begin
      best_q     <= pncm_pkg::BestW'(dsum);
      best_idx_q <= s2_idx_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((pop_o && !q_item_i.is_match) || fin) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !q_item_i.is_match) begin
      out_idx_q  <= '0;
      out_dist_q <= '0;
      out_ign_q  <= q_item_i.blocked;
    end else if (fin) begin
      out_idx_q  <= pncm_pkg::FieldIdxW'(take ? s2_idx_q : best_idx_q);
      out_dist_q <= take ? dsum : best_q[pncm_pkg::DistW-1:0];
      out_ign_q  <= 1'b0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign match_index_o    = out_idx_q;
  assign match_distance_o = out_dist_q;
  assign write_ignored_o  = out_ign_q;

endmodule

`default_nettype wire

@@ sv/palette_nearest_colour_match_unit.sv @@
`default_nettype none

// channel | valid / stall          | payload
// --------+------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o   | action_i entry_index_i red_i green_i blue_i
// out     | out_valid_o / out_stall_i | match_index_o match_distance_o write_ignored_o
//
// A write beat needs no scan; a match beat scans, reading one palette entry per
// cycle from the single-port palette memory, then a square and a compare stage.
// A two-deep queue holds input beats while the back end scans or the result is stalled.
// Reset clears per-entry valid flags at once; no clearing pass is run.

module palette_nearest_colour_match_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             action_i,
  input  wire logic [pncm_pkg::FieldIdxW-1:0]   entry_index_i,
  input  wire logic [pncm_pkg::ChanW-1:0]       red_i,
  input  wire logic [pncm_pkg::ChanW-1:0]       green_i,
  input  wire logic [pncm_pkg::ChanW-1:0]       blue_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [pncm_pkg::FieldIdxW-1:0]        match_index_o,
  output logic [pncm_pkg::DistW-1:0]            match_distance_o,
  output logic                                  write_ignored_o
);

  pncm_pkg::item_t push_item, head_item;
  logic push, q_full, q_valid, pop;

  pncm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  pncm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  pncm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .match_index_o    (match_index_o),
    .match_distance_o (match_distance_o),
    .write_ignored_o  (write_ignored_o)
  );

endmodule

`default_nettype wire
